[rtl/mi3_pkg.sv]
package mi3_pkg;

    // element and intermediate widths
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = 2 * IN_W;          // element product
    localparam int CROSS_W = PROD_W + 1;        // cross product component
    localparam int DPROD_W = CROSS_W + IN_W;    // cross times element
    localparam int DET_W   = DPROD_W + 2;       // sum of three
    localparam int DMAG_W  = 50;                // |det| < 2^48 for Q8.8 inputs
    localparam int QW      = 32;                // quotient bits kept
    localparam int FRAC_SH = 24;                // Q8.8 squared over Q8.8 cubed to Q16.16
    localparam int NDIV    = 9;

    typedef logic signed [IN_W-1:0]    t_elem;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [DPROD_W-1:0] t_dprod;
    typedef logic signed [DET_W-1:0]   t_det;
    typedef logic [DMAG_W-1:0]         t_dmag;
    typedef logic [QW-1:0]             t_quo;
    typedef logic signed [OUT_W-1:0]   t_out;

    // index of the next and the one after next, modulo 3
    localparam int NX [0:2] = '{1, 2, 0};
    localparam int NY [0:2] = '{2, 0, 1};

    localparam t_out SAT_POS = t_out'({1'b0, {(OUT_W-1){1'b1}}});
    localparam t_out SAT_NEG = t_out'({1'b1, {(OUT_W-1){1'b0}}});

endpackage

[rtl/matrix_inverse_3x3_core.sv]
// 3x3 matrix inverse by adjugate, signed Q8.8 in, signed Q16.16 out
//
// input channel: drive the nine elements and pulse start; a beat is taken
// at every edge with start high and busy low. busy is always low, so a new
// matrix may enter in every cycle.
// result channel: o_done is high for exactly one cycle with the nine inverse
// elements and o_singular; the receiver must take the beat in that cycle.
// throughput: one matrix per cycle. The pipeline holds the input register,
// products, cross products, determinant terms, determinant sum, divider
// setup, then 32 restoring division stages (one quotient bit per stage, nine
// dividers in parallel) and the output register.
// elements are truncated toward zero and saturated to 32 bits; a zero
// determinant gives o_singular high and all elements zero.
// reset (synchronous, active low) clears the valid bits only; beats in
// flight are dropped and no result comes out for them.
module matrix_inverse_3x3_core
    import mi3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [IN_W-1:0] i_in_r0c0,
    input  logic signed [IN_W-1:0] i_in_r0c1,
    input  logic signed [IN_W-1:0] i_in_r0c2,
    input  logic signed [IN_W-1:0] i_in_r1c0,
    input  logic signed [IN_W-1:0] i_in_r1c1,
    input  logic signed [IN_W-1:0] i_in_r1c2,
    input  logic signed [IN_W-1:0] i_in_r2c0,
    input  logic signed [IN_W-1:0] i_in_r2c1,
    input  logic signed [IN_W-1:0] i_in_r2c2,
    output logic        o_done,
    output logic signed [OUT_W-1:0] o_inv_r0c0,
    output logic signed [OUT_W-1:0] o_inv_r0c1,
    output logic signed [OUT_W-1:0] o_inv_r0c2,
    output logic signed [OUT_W-1:0] o_inv_r1c0,
    output logic signed [OUT_W-1:0] o_inv_r1c1,
    output logic signed [OUT_W-1:0] o_inv_r1c2,
    output logic signed [OUT_W-1:0] o_inv_r2c0,
    output logic signed [OUT_W-1:0] o_inv_r2c1,
    output logic signed [OUT_W-1:0] o_inv_r2c2,
    output logic        o_singular
);

    // stage 1: input register, r_m[row][col]
    t_elem  r_m [0:2][0:2];
    logic   r_v1;
    // stage 2: element products for the three cross products
    t_prod  r_pa [0:2][0:2];
    t_prod  r_pb [0:2][0:2];
    t_elem  r_c2 [0:2];
    logic   r_v2;
    // stage 3: cross products, r_x[row of inverse][col]
    t_cross r_x3 [0:2][0:2];
    t_elem  r_c3 [0:2];
    logic   r_v3;
    // stage 4: determinant terms
    t_dprod r_dp [0:2];
    t_cross r_x4 [0:2][0:2];
    logic   r_v4;
    // stage 5: determinant
    t_det   r_det;
    t_cross r_x5 [0:2][0:2];
    logic   r_v5;
    // divider stages, index 0 is the setup stage
    t_dmag  r_rem [0:QW][0:NDIV-1];
    t_quo   r_w   [0:QW][0:NDIV-1];
    t_dmag  r_d   [0:QW];
    logic [NDIV-1:0] r_neg [0:QW];
    logic [NDIV-1:0] r_ovf [0:QW];
    logic   r_sg  [0:QW];
    logic   r_dv  [0:QW];
    // output register
    t_out   r_out [0:NDIV-1];
    logic   r_sing;
    logic   r_ov;

    t_dmag  n_rem [1:QW][0:NDIV-1];
    t_quo   n_w   [1:QW][0:NDIV-1];
    t_dmag  n_rem0 [0:NDIV-1];
    t_quo   n_w0   [0:NDIV-1];
    logic [NDIV-1:0] n_neg0;
    logic [NDIV-1:0] n_ovf0;
    t_dmag  n_d0;
    t_out   n_out [0:NDIV-1];

    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int s = 0; s <= QW; s++) r_dv[s] <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_dv[0] <= r_v5;
            for (int s = 1; s <= QW; s++) r_dv[s] <= r_dv[s-1];
            r_ov <= r_dv[QW];
        end
    end

    // front end: products, cross products, determinant
    always_ff @(posedge i_clk) begin
        r_m[0][0] <= i_in_r0c0; r_m[0][1] <= i_in_r0c1; r_m[0][2] <= i_in_r0c2;
        r_m[1][0] <= i_in_r1c0; r_m[1][1] <= i_in_r1c1; r_m[1][2] <= i_in_r1c2;
        r_m[2][0] <= i_in_r2c0; r_m[2][1] <= i_in_r2c1; r_m[2][2] <= i_in_r2c2;
        // row k of the inverse is column NX[k] cross column NY[k]
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_pa[k][j] <= t_prod'(r_m[NX[j]][NX[k]]) * t_prod'(r_m[NY[j]][NY[k]]);
                r_pb[k][j] <= t_prod'(r_m[NY[j]][NX[k]]) * t_prod'(r_m[NX[j]][NY[k]]);
            end
            r_c2[k] <= r_m[k][2];
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_x3[k][j] <= t_cross'(r_pa[k][j]) - t_cross'(r_pb[k][j]);
            end
            r_c3[k] <= r_c2[k];
        end
        for (int j = 0; j < 3; j++) begin
            r_dp[j] <= t_dprod'(r_x3[2][j]) * t_dprod'(r_c3[j]);
        end
        r_x4 <= r_x3;
        r_det <= t_det'(r_dp[0]) + t_det'(r_dp[1]) + t_det'(r_dp[2]);
        r_x5 <= r_x4;
    end

    // divider setup: magnitudes, signs, overflow of the top quotient bits
    always_comb begin
        t_det   dabs;
        t_cross xabs;
        dabs = r_det[DET_W-1] ? -r_det : r_det;
        n_d0 = dabs[DMAG_W-1:0];
        for (int k = 0; k < NDIV; k++) begin
            xabs = r_x5[k/3][k%3][CROSS_W-1] ? -r_x5[k/3][k%3] : r_x5[k/3][k%3];
            n_neg0[k] = r_x5[k/3][k%3][CROSS_W-1] ^ r_det[DET_W-1];
            // numerator is |x| << 24; its bits above the low 32 seed the remainder
            n_rem0[k] = t_dmag'(xabs[QW-1:QW-FRAC_SH]);
            n_w0[k]   = {xabs[QW-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            n_ovf0[k] = n_rem0[k] >= n_d0;
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [DMAG_W:0] t;
        logic            b;
        for (int s = 1; s <= QW; s++) begin
            for (int k = 0; k < NDIV; k++) begin
                t = {r_rem[s-1][k], r_w[s-1][k][QW-1]};
                b = t >= {1'b0, r_d[s-1]};
                n_rem[s][k] = b ? t[DMAG_W-1:0] - r_d[s-1] : t[DMAG_W-1:0];
                n_w[s][k]   = {r_w[s-1][k][QW-2:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_w[0]   <= n_w0;
        r_d[0]   <= n_d0;
        r_neg[0] <= n_neg0;
        r_ovf[0] <= n_ovf0;
        r_sg[0]  <= (r_det == '0);
        for (int s = 1; s <= QW; s++) begin
            r_rem[s] <= n_rem[s];
            r_w[s]   <= n_w[s];
            r_d[s]   <= r_d[s-1];
            r_neg[s] <= r_neg[s-1];
            r_ovf[s] <= r_ovf[s-1];
            r_sg[s]  <= r_sg[s-1];
        end
    end

    // sign, saturation and singular zeroing
    always_comb begin
        t_quo q;
        for (int k = 0; k < NDIV; k++) begin
            q = r_w[QW][k];
            if (r_sg[QW]) begin
                n_out[k] = '0;
            end else if (r_neg[QW][k]) begin
                if (r_ovf[QW][k] || (q > t_quo'(SAT_NEG))) n_out[k] = SAT_NEG;
                else n_out[k] = t_out'(-q);
            end else begin
                if (r_ovf[QW][k] || q[QW-1]) n_out[k] = SAT_POS;
                else n_out[k] = t_out'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_sing <= r_sg[QW];
    end

    assign o_done     = r_ov;
    assign o_singular = r_sing;
    assign o_inv_r0c0 = r_out[0];
    assign o_inv_r0c1 = r_out[1];
    assign o_inv_r0c2 = r_out[2];
    assign o_inv_r1c0 = r_out[3];
    assign o_inv_r1c1 = r_out[4];
    assign o_inv_r1c2 = r_out[5];
    assign o_inv_r2c0 = r_out[6];
    assign o_inv_r2c1 = r_out[7];
    assign o_inv_r2c2 = r_out[8];

endmodule
